### design/plst_pkg.sv
package plst_pkg;

    // Fixed field widths
    localparam int unsigned FUNC_W = 3;
    localparam int unsigned POS_W  = 7;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned ERR_W  = 2;

    // Default list depth
    localparam int unsigned DEF_CAPACITY = 64;

    // Answer for an absent entry and floor of the maximum, and the default answer
    localparam logic signed [DATA_W-1:0] ANS_NONE = -32'sd1;
    localparam logic signed [DATA_W-1:0] ANS_ZERO = 32'sd0;

    // Operation codes
    typedef enum logic [FUNC_W-1:0] {
        FN_LEN  = 3'd0,
        FN_INS  = 3'd1,
        FN_RD   = 3'd2,
        FN_REM  = 3'd3,
        FN_MOVE = 3'd4,
        FN_MAX  = 3'd5
    } t_func;

    // Result error codes
    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 2'd0,
        ERR_RANGE = 2'd1,
        ERR_FULL  = 2'd2
    } t_err;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_ISSUE,
        ST_RD_TAKE,
        ST_MV_RD,
        ST_MV_TAKE,
        ST_SHIFT,
        ST_DRAIN,
        ST_PUT,
        ST_MAX,
        ST_MAX_LAST,
        ST_DONE
    } t_state;

    // One finished result
    typedef struct packed {
        logic signed [DATA_W-1:0] answer;
        t_err                     error;
    } t_result;

endpackage

### design/plst_mem.sv
module plst_mem #(
    parameter int unsigned DEPTH = plst_pkg::DEF_CAPACITY,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [plst_pkg::DATA_W-1:0]   i_wdata,
    input  logic [AW-1:0]                 i_raddr,
    output logic [plst_pkg::DATA_W-1:0]   o_rdata
);
    import plst_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // One write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // One read port, registered data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/plst_ctrl.sv
module plst_ctrl #(
    parameter int unsigned CAPACITY = plst_pkg::DEF_CAPACITY,
    parameter int unsigned AW       = $clog2(CAPACITY)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // item channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [plst_pkg::FUNC_W-1:0]   i_func,
    input  logic [plst_pkg::POS_W-1:0]    i_position,
    input  logic [plst_pkg::DATA_W-1:0]   i_value,
    // result towards the output register
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output plst_pkg::t_result             o_res,
    // memory port
    output logic                          o_we,
    output logic [AW-1:0]                 o_waddr,
    output logic [plst_pkg::DATA_W-1:0]   o_wdata,
    output logic [AW-1:0]                 o_raddr,
    input  logic [plst_pkg::DATA_W-1:0]   i_rdata
);
    import plst_pkg::*;

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned WW = ((CW > POS_W) ? CW : POS_W) + 1;

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    t_func                    r_func,  n_func;
    logic [AW-1:0]            r_pos,   n_pos;
    logic [DATA_W-1:0]        r_val,   n_val;
    logic [AW-1:0]            r_addr,  n_addr;
    logic [AW-1:0]            r_end,   n_end;
    logic [AW-1:0]            r_wtgt,  n_wtgt;
    logic                     r_pend,  n_pend;
    logic                     r_up,    n_up;
    logic signed [DATA_W-1:0] r_answer, n_answer;
    t_err                     r_error,  n_error;

    logic [WW-1:0]            pos_w;
    logic [WW-1:0]            cnt_w;
    logic                     pos_ge;
    logic                     pos_gt;
    logic                     pos_last;
    logic                     full;
    logic [AW-1:0]            in_pos;
    logic [AW-1:0]            cnt_m1;
    logic signed [DATA_W-1:0] rdata_s;

    // Position checks against the current length
    assign pos_w    = WW'(i_position);
    assign cnt_w    = WW'(r_count);
    assign pos_ge   = (pos_w >= cnt_w);
    assign pos_gt   = (pos_w > cnt_w);
    assign pos_last = (pos_w + WW'(1) == cnt_w);
    assign full     = (r_count == CW'(CAPACITY));
    assign in_pos   = AW'(pos_w);
    assign cnt_m1   = AW'(r_count - CW'(1));
    assign rdata_s  = $signed(i_rdata);

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_addr   <= n_addr;
        r_end    <= n_end;
        r_wtgt   <= n_wtgt;
        r_up     <= n_up;
        r_answer <= n_answer;
        r_error  <= n_error;
    end

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_func   = r_func;
        n_pos    = r_pos;
        n_val    = r_val;
        n_addr   = r_addr;
        n_end    = r_end;
        n_wtgt   = r_wtgt;
        n_pend   = 1'b0;
        n_up     = r_up;
        n_answer = r_answer;
        n_error  = r_error;
        o_ready     = 1'b0;
        o_res_valid = 1'b0;
        o_we        = 1'b0;
        o_waddr     = r_wtgt;
        o_wdata     = i_rdata;
        o_raddr     = r_addr;

        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_func   = t_func'(i_func);
                    n_pos    = in_pos;
                    n_val    = i_value;
                    n_answer = ANS_ZERO;
                    n_error  = ERR_OK;
                    n_state  = ST_DONE;
                    unique case (t_func'(i_func))
                        FN_LEN: begin
                            n_answer = DATA_W'(r_count);
                        end
                        FN_INS: begin
                            priority if (pos_gt) begin
                                n_error = ERR_RANGE;
                            end else if (full) begin
                                n_error = ERR_FULL;
                            end else if (pos_ge) begin
                                // append at the end, nothing to shift
                                n_state = ST_PUT;
                            end else begin
                                n_addr  = cnt_m1;
                                n_end   = in_pos;
                                n_up    = 1'b1;
                                n_state = ST_SHIFT;
                            end
                        end
                        FN_RD: begin
                            if (pos_ge) begin
                                n_answer = ANS_NONE;
                            end else begin
                                n_state = ST_RD_ISSUE;
                            end
                        end
                        FN_REM: begin
                            priority if (pos_ge) begin
                                n_error = ERR_RANGE;
                            end else if (pos_last) begin
                                n_count = r_count - CW'(1);
                            end else begin
                                n_addr  = in_pos + AW'(1);
                                n_end   = cnt_m1;
                                n_up    = 1'b0;
                                n_state = ST_SHIFT;
                            end
                        end
                        FN_MOVE: begin
                            priority if (pos_ge) begin
                                n_error = ERR_RANGE;
                            end else if (!pos_last) begin
                                // last entry moved onto itself is a no-op
                                n_addr  = in_pos + AW'(1);
                                n_end   = cnt_m1;
                                n_up    = 1'b0;
                                n_state = ST_MV_RD;
                            end
                        end
                        FN_MAX: begin
                            n_answer = ANS_NONE;
                            if (r_count != '0) begin
                                n_addr  = '0;
                                n_end   = cnt_m1;
                                n_state = ST_MAX;
                            end
                        end
                        default: begin
                            // unused codes: no result
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RD_ISSUE: begin
                o_raddr = r_pos;
                n_state = ST_RD_TAKE;
            end
            ST_RD_TAKE: begin
                n_answer = rdata_s;
                n_state  = ST_DONE;
            end
            ST_MV_RD: begin
                o_raddr = r_pos;
                n_state = ST_MV_TAKE;
            end
            ST_MV_TAKE: begin
                // hold the moved entry until the tail write
                n_val   = i_rdata;
                n_state = ST_SHIFT;
            end
            ST_SHIFT: begin
                // read one entry, write the previous read one step over
                o_raddr = r_addr;
                n_pend  = 1'b1;
                n_wtgt  = r_up ? (r_addr + AW'(1)) : (r_addr - AW'(1));
                o_we    = r_pend;
                if (r_addr == r_end) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_addr = r_up ? (r_addr - AW'(1)) : (r_addr + AW'(1));
                end
            end
            ST_DRAIN: begin
                o_we = 1'b1;
                if (r_func == FN_REM) begin
                    n_count = r_count - CW'(1);
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_PUT;
                end
            end
            ST_PUT: begin
                o_we    = 1'b1;
                o_wdata = r_val;
                if (r_func == FN_INS) begin
                    o_waddr = r_pos;
                    n_count = r_count + CW'(1);
                end else begin
                    o_waddr = cnt_m1;
                end
                n_state = ST_DONE;
            end
            ST_MAX: begin
                o_raddr = r_addr;
                n_pend  = 1'b1;
                if (r_pend && (rdata_s > r_answer)) begin
                    n_answer = rdata_s;
                end
                if (r_addr == r_end) begin
                    n_state = ST_MAX_LAST;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            ST_MAX_LAST: begin
                if (rdata_s > r_answer) begin
                    n_answer = rdata_s;
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_res.answer = r_answer;
    assign o_res.error  = r_error;

endmodule

### design/positional_list_engine.sv
// Length, rejected items, a read past the end and a remove or move of the last entry answer
// without a memory access; a read makes one memory read; insert, remove and move shift the tail
// of the list (an append shifts nothing), and maximum scans every entry (none when empty).
// Throughput: one item at a time; the shift and the maximum scan stream through the write and
// read ports of the entry memory at one entry per cycle.
// A new item is taken while the previous result waits in the output register.
// Reset: synchronous, active low; the list is empty afterwards, memory contents untouched.
module positional_list_engine #(
    parameter int unsigned CAPACITY = plst_pkg::DEF_CAPACITY
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [plst_pkg::FUNC_W-1:0]         i_func,
    input  logic [plst_pkg::POS_W-1:0]          i_position,
    input  logic signed [plst_pkg::DATA_W-1:0]  i_value,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [plst_pkg::DATA_W-1:0]  o_answer,
    output logic [plst_pkg::ERR_W-1:0]          o_error
);
    import plst_pkg::*;

    localparam int unsigned AW = $clog2(CAPACITY);

    logic              res_valid;
    logic              res_ready;
    t_result           res;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    logic              r_o_valid, n_o_valid;
    t_result           r_out,     n_out;

    plst_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_func      (i_func),
        .i_position  (i_position),
        .i_value     (i_value),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_we        (mem_we),
        .o_waddr     (mem_waddr),
        .o_wdata     (mem_wdata),
        .o_raddr     (mem_raddr),
        .i_rdata     (mem_rdata)
    );

    plst_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Output register: free when empty or being drained this cycle
    assign res_ready = !r_o_valid || i_ready;

    always_comb begin
        n_o_valid = r_o_valid;
        n_out     = r_out;
        if (res_ready) begin
            n_o_valid = res_valid;
            if (res_valid) begin
                n_out = res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid  = r_o_valid;
    assign o_answer = r_out.answer;
    assign o_error  = r_out.error;

endmodule

### design/plst_chk.sv
module plst_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_ready,
    input logic [plst_pkg::FUNC_W-1:0]         i_func,
    input logic                                o_valid,
    input logic                                i_ready,
    input logic signed [plst_pkg::DATA_W-1:0]  o_answer,
    input logic [plst_pkg::ERR_W-1:0]          o_error
);
    import plst_pkg::*;

    // No result straight out of reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // One item in flight: no transfer in the cycle after a transfer of a used code
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_func <= FN_MAX)) |=> !o_ready)
        else $error("input ready right after an item transfer");

    // Rejected items carry a zero answer
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_error != ERR_OK)) |-> (o_answer == ANS_ZERO))
        else $error("rejected item with non-zero answer");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_answer) && $stable(o_error)))
        else $error("stalled result changed");

endmodule

bind positional_list_engine plst_chk u_plst_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_ready  (o_ready),
    .i_func   (i_func),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_answer (o_answer),
    .o_error  (o_error)
);

### tb/sv/tb_positional_list_engine.sv
`timescale 1ns / 1ps

module tb_positional_list_engine;

    import plst_pkg::*;

    localparam int CAP         = DEF_CAPACITY;
    localparam int RANDOM_OPS  = 1325;
    // worst single op is a full shift or scan, plus output hold and sender gap
    localparam int OP_CYCLES   = DEF_CAPACITY + 5;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 10 * (HOLD_CYCLES + OP_CYCLES + 16);
    localparam int DRAIN_WAIT  = 2 * OP_CYCLES + 20;
    localparam int PRINT_LIMIT = 40;

    // operation codes the block ignores
    localparam logic [FUNC_W-1:0] FN_UNUSED_A = 3'd6;
    localparam logic [FUNC_W-1:0] FN_UNUSED_B = 3'd7;

    // stimulus phase kinds
    localparam int PH_GROW   = 0;
    localparam int PH_SHRINK = 1;
    localparam int PH_MIXED  = 2;
    localparam int PH_FILL   = 3;
    localparam int PH_MOVE   = 4;

    typedef struct {
        logic [FUNC_W-1:0]        func;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] value;
    } list_cmd_t;

    logic                       i_clk      = 1'b0;
    logic                       i_rst_n    = 1'b0;
    logic                       i_valid    = 1'b0;
    logic                       o_ready;
    logic [FUNC_W-1:0]          i_func     = '0;
    logic [POS_W-1:0]           i_position = '0;
    logic signed [DATA_W-1:0]   i_value    = '0;
    logic                       o_valid;
    logic                       i_ready    = 1'b0;
    logic signed [DATA_W-1:0]   o_answer;
    logic [ERR_W-1:0]           o_error;

    // stimulus and prediction state
    list_cmd_t                  pending_cmds[$];
    t_result                    answers_due[$];
    logic signed [DATA_W-1:0]   list_vals[CAP];
    int                         list_len    = 0;
    int                         planned_len = 0;
    int                         total_cmds  = 0;
    int                         taken_count = 0;
    int                         fail_count  = 0;
    int                         idle_cycles = 0;

    // sender and receiver pacing
    int                         burst_left  = 0;
    int                         gap_left    = 0;
    list_cmd_t                  next_cmd;
    int                         hold_left   = 0;
    int                         holds_done  = 0;
    int                         rx_mode     = 0;
    int                         mode_left   = 0;
    int                         rx_tick     = 0;

    positional_list_engine dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_func     (i_func),
        .i_position (i_position),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_answer   (o_answer),
        .o_error    (o_error)
    );

    always #10 i_clk = ~i_clk;

    // Apply one accepted operation to the list and queue the answer it gives
    task automatic apply_list_op(input logic [FUNC_W-1:0] func,
                                 input logic [POS_W-1:0] pos,
                                 input logic signed [DATA_W-1:0] value);
        t_result                  res;
        logic signed [DATA_W-1:0] moved;
        logic signed [DATA_W-1:0] best;
        int                       p;
        int                       k;
        bit                       emits;
        p          = int'(pos);
        emits      = 1'b1;
        res.answer = ANS_ZERO;
        res.error  = ERR_OK;
        case (func)
            FN_LEN: begin
                res.answer = DATA_W'(list_len);
            end
            FN_INS: begin
                if (p > list_len) begin
                    res.error = ERR_RANGE;
                end else if (list_len >= CAP) begin
                    res.error = ERR_FULL;
                end else begin
                    for (k = list_len; k > p; k--)
                        list_vals[k] = list_vals[k-1];
                    list_vals[p] = value;
                    list_len++;
                end
            end
            FN_RD: begin
                res.answer = (p >= list_len) ? ANS_NONE : list_vals[p];
            end
            FN_REM, FN_MOVE: begin
                if (p >= list_len) begin
                    res.error = ERR_RANGE;
                end else begin
                    moved = list_vals[p];
                    for (k = p; k + 1 < list_len; k++)
                        list_vals[k] = list_vals[k+1];
                    if (func == FN_MOVE)
                        list_vals[list_len-1] = moved;
                    else
                        list_len--;
                end
            end
            FN_MAX: begin
                // floor of -1, so an empty list or all-negative list gives -1
                best = ANS_NONE;
                for (k = 0; k < list_len; k++)
                    if (list_vals[k] > best)
                        best = list_vals[k];
                res.answer = best;
            end
            default: begin
                emits = 1'b0;
            end
        endcase
        if (emits)
            answers_due.push_back(res);
    endtask

    // Queue a command, tracking only the list length it will leave behind
    task automatic queue_op(input logic [FUNC_W-1:0] func, input int pos,
                            input logic signed [DATA_W-1:0] value);
        list_cmd_t c;
        c.func  = func;
        c.pos   = POS_W'(pos);
        c.value = value;
        pending_cmds.push_back(c);
        if (func == FN_INS && pos <= planned_len && planned_len < CAP)
            planned_len++;
        else if (func == FN_REM && pos < planned_len)
            planned_len--;
    endtask

    function automatic logic signed [DATA_W-1:0] rand_value();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(0, 7))
            0, 1, 2: v = $urandom;
            3:       v = $urandom_range(0, 16) - 32'd8;
            4:       v = 32'h8000_0000;
            5:       v = 32'h7FFF_FFFF;
            6:       v = 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: v = $urandom | 32'h8000_0000;
        endcase
        return v;
    endfunction

    // Mostly a legal position, sometimes just past the end, sometimes anything
    function automatic int pick_pos(input int first_bad);
        int r;
        r = $urandom_range(0, 99);
        if (r < 84 && first_bad > 0)
            return $urandom_range(0, first_bad - 1);
        if (r < 94)
            return $urandom_range(first_bad, first_bad + 2);
        return $urandom_range(0, (1 << POS_W) - 1);
    endfunction

    function automatic logic [FUNC_W-1:0] pick_func(input int kind);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return r[0] ? FN_UNUSED_A : FN_UNUSED_B;
        r = $urandom_range(0, 99);
        case (kind)
            PH_GROW: begin
                if (r < 60) return FN_INS;
                if (r < 75) return FN_RD;
                if (r < 85) return FN_REM;
                if (r < 90) return FN_LEN;
                if (r < 95) return FN_MAX;
                return FN_MOVE;
            end
            PH_SHRINK: begin
                if (r < 50) return FN_REM;
                if (r < 65) return FN_INS;
                if (r < 75) return FN_RD;
                if (r < 85) return FN_MOVE;
                if (r < 95) return FN_MAX;
                return FN_LEN;
            end
            PH_MOVE: begin
                if (r < 40) return FN_MOVE;
                if (r < 70) return FN_RD;
                if (r < 90) return FN_MAX;
                return FN_LEN;
            end
            default: begin
                return FN_LEN + FUNC_W'(r % 6);
            end
        endcase
    endfunction

    // Build the stimulus, release reset, then wait for everything to drain
    initial begin
        int                n_ops;
        int                kind;
        int                plen;
        int                j;
        logic [FUNC_W-1:0] f;

        // empty list: every access out of range, unused codes
        queue_op(FN_LEN, 0, 0);
        queue_op(FN_MAX, 0, 0);
        queue_op(FN_RD, 0, 0);
        queue_op(FN_REM, 0, 0);
        queue_op(FN_MOVE, 0, 0);
        queue_op(FN_INS, 1, 32'h1234_5678);
        queue_op(FN_INS, 127, 32'h0F0F_0F0F);
        queue_op(FN_UNUSED_A, 127, 32'hFFFF_FFFF);
        queue_op(FN_UNUSED_B, 0, 32'h0000_0000);
        // only values below -1: maximum stays at the floor
        queue_op(FN_INS, 0, 32'h8000_0000);
        queue_op(FN_INS, 0, -32'sd5);
        queue_op(FN_MAX, 0, 0);
        // insert at the end and in the middle, extremes of value
        queue_op(FN_INS, 2, 32'h7FFF_FFFF);
        queue_op(FN_INS, 1, 32'h5555_5555);
        queue_op(FN_MAX, 0, 0);
        queue_op(FN_RD, 3, 0);
        queue_op(FN_RD, 64, 0);
        queue_op(FN_RD, 127, 0);
        // move the head and the tail, remove past the end, tail and head
        queue_op(FN_MOVE, 0, 0);
        queue_op(FN_MOVE, 3, 0);
        queue_op(FN_REM, 4, 0);
        queue_op(FN_REM, 3, 0);
        queue_op(FN_REM, 0, 0);
        queue_op(FN_LEN, 0, 0);
        queue_op(FN_RD, 1, 0);

        // random phases; the first one fills the list to capacity
        n_ops = 0;
        kind  = PH_FILL;
        while (n_ops < RANDOM_OPS) begin
            plen = (kind == PH_FILL) ? 90 : $urandom_range(10, 60);
            for (j = 0; j < plen; j++) begin
                if (kind == PH_FILL && (planned_len < CAP || $urandom_range(0, 99) < 40))
                    f = FN_INS;
                else
                    f = pick_func(kind == PH_FILL ? PH_MIXED : kind);
                case (f)
                    FN_INS:
                        queue_op(f, pick_pos(planned_len + 1), rand_value());
                    FN_RD, FN_REM, FN_MOVE:
                        queue_op(f, pick_pos(planned_len), $urandom);
                    default:
                        queue_op(f, $urandom_range(0, (1 << POS_W) - 1), $urandom);
                endcase
                if (f != FN_UNUSED_A && f != FN_UNUSED_B)
                    n_ops++;
            end
            kind = $urandom_range(PH_GROW, PH_MOVE);
        end
        total_cmds = pending_cmds.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(posedge i_clk);
        while (taken_count != total_cmds || answers_due.size() != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Sender: bursts of transfers with random gaps, payload held until taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (i_valid && o_ready) begin
                apply_list_op(i_func, i_position, i_value);
                taken_count <= taken_count + 1;
            end
            if (!i_valid || o_ready) begin
                if (burst_left == 0) begin
                    if ($urandom_range(0, 3) == 0) begin
                        burst_left = $urandom_range(100, 300);
                        gap_left   = 0;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = $urandom_range(1, 12);
                    end
                end
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    next_cmd = pending_cmds.pop_front();
                    i_func     <= next_cmd.func;
                    i_position <= next_cmd.pos;
                    i_value    <= next_cmd.value;
                    i_valid    <= 1'b1;
                    burst_left--;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: long hold-offs at two points, otherwise a changing stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if ((holds_done == 0 && taken_count >= 200) ||
                     (holds_done == 1 && taken_count >= 800)) begin
            hold_left = HOLD_CYCLES;
            holds_done++;
            i_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = $urandom_range(0, 3);
                mode_left = $urandom_range(32, 256);
            end else begin
                mode_left--;
            end
            rx_tick++;
            case (rx_mode)
                0:       i_ready <= 1'b1;
                1:       i_ready <= $urandom_range(0, 1) == 1;
                2:       i_ready <= $urandom_range(0, 3) == 0;
                default: i_ready <= (rx_tick % 7) < 3;
            endcase
        end
    end

    // Monitor: compare each result transfer with the oldest predicted answer
    always @(posedge i_clk) begin
        t_result exp_res;
        if (i_rst_n && o_valid && i_ready) begin
            if (answers_due.size() == 0) begin
                if (fail_count < PRINT_LIMIT)
                    $display("%0t: unexpected result: answer %0d error %0d",
                             $time, o_answer, o_error);
                fail_count++;
            end else begin
                exp_res = answers_due.pop_front();
                if (o_answer !== exp_res.answer) begin
                    if (fail_count < PRINT_LIMIT)
                        $display("%0t: answer mismatch: expected %0d, got %0d",
                                 $time, exp_res.answer, o_answer);
                    fail_count++;
                end
                if (o_error !== exp_res.error) begin
                    if (fail_count < PRINT_LIMIT)
                        $display("%0t: error mismatch: expected %0d, got %0d",
                                 $time, exp_res.error, o_error);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: too long without any transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d answers outstanding",
                     $time, idle_cycles, answers_due.size());
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

### files.f
design/plst_pkg.sv
design/plst_mem.sv
design/plst_ctrl.sv
design/positional_list_engine.sv
design/plst_chk.sv
tb/sv/tb_positional_list_engine.sv
